// ===== hw/rtl/smv_pkg.sv =====
// Shared types, codes and constants of the sample voice mixer.
package smv_pkg;

  localparam int VOICE_COUNT_DEF  = 16;
  localparam int SAMPLE_WORDS_DEF = 65536;

  localparam int FUNC_W   = 2;
  localparam int VOICE_W  = 4;
  localparam int ADDR_W   = 16;
  localparam int LEN_W    = 17;
  localparam int VEL_W    = 7;
  localparam int SAMPLE_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  // floor(2^22 / 127); quotient estimate is exact or one low
  localparam logic [15:0] GAIN_RECIP = 16'd33026;
  localparam int          RECIP_SHIFT = 22;
  localparam logic [7:0]  GAIN_DIV = 8'd127;

  localparam logic signed [17:0] MIX_MAX = 18'sd32767;
  localparam logic signed [17:0] MIX_MIN = -18'sd32768;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  position;
    logic [VEL_W-1:0]  gain;
  } voice_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic last;
  } mix_ctl_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] sum;
  } mix_res_t;

endpackage

// ===== hw/rtl/smv_if.sv =====
// Valid/ready channel interfaces for the mixer's input and result words.
interface smv_in_if
  import smv_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [VOICE_W-1:0]         voice;
  logic [ADDR_W-1:0]          address;
  logic [LEN_W-1:0]           sample_length;
  logic [VEL_W-1:0]           velocity;
  logic signed [SAMPLE_W-1:0] sample_word;

  modport source (output valid, func, voice, address, sample_length, velocity, sample_word,
                  input ready);
  modport sink (input valid, func, voice, address, sample_length, velocity, sample_word,
                output ready);
endinterface

interface smv_out_if
  import smv_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

// ===== hw/rtl/smv_sample_mem.sv =====
// Sample word memory: one write port, one registered read port.
module smv_sample_mem
  import smv_pkg::*;
#(
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
  localparam int AW = $clog2(SAMPLE_WORDS)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [SAMPLE_WORDS];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/smv_voice_table.sv =====
// Voice parameter memory: start, length, position and gain per voice slot.
module smv_voice_table
  import smv_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF,
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [VW-1:0] wr_addr,
  input  voice_t        wr_data,
  input  logic          rd_en,
  input  logic [VW-1:0] rd_addr,
  output voice_t        rd_data
);

  voice_t mem [VOICE_COUNT];
  voice_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/smv_gain_acc.sv =====
// Gain scaling by velocity/127 and saturating accumulation of one frame.
module smv_gain_acc
  import smv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  mix_ctl_t                   ctl_in,
  input  logic [VEL_W-1:0]           gain_in,
  input  logic signed [SAMPLE_W-1:0] sample,
  output mix_res_t                   res
);

  localparam int MAG_W  = 22;
  localparam int PROD_W = MAG_W + 16;

  mix_ctl_t                   ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [VEL_W-1:0]           gain2_r;
  logic [MAG_W-1:0]           mag3_r, mag4_r;
  logic                       neg3_r, neg4_r, neg5_r;
  logic [PROD_W-1:0]          prod4_r;
  logic [15:0]                q5_r;
  logic signed [SAMPLE_W-1:0] sum_r;

  logic [SAMPLE_W-1:0]        abs_s;
  logic [MAG_W-1:0]           mag_full;
  logic [15:0]                q_est;
  logic [MAG_W:0]             q_times;
  logic [MAG_W:0]             rem;
  logic [15:0]                q;
  logic signed [16:0]         scaled;
  logic signed [17:0]         acc;
  logic signed [SAMPLE_W-1:0] sum_nxt;

  // stage 2: magnitude of sample * gain
  assign abs_s    = sample[SAMPLE_W-1] ? (~sample + 16'd1) : sample;
  assign mag_full = abs_s * gain2_r;

  // stage 4: exact divide by 127 from the reciprocal estimate
  assign q_est   = prod4_r[PROD_W-1:RECIP_SHIFT];
  assign q_times = {q_est, 7'b0} - {7'b0, q_est};
  assign rem     = {1'b0, mag4_r} - q_times;
  assign q       = (rem >= {15'b0, GAIN_DIV}) ? q_est + 16'd1 : q_est;

  // stage 5: apply the sign and accumulate
  assign scaled  = neg5_r ? -$signed({1'b0, q5_r}) : $signed({1'b0, q5_r});
  assign acc     = 18'(sum_r) + 18'(scaled);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl5_r.vld && ctl5_r.hit) begin
      if (acc > MIX_MAX) begin
        sum_nxt = MIX_MAX[SAMPLE_W-1:0];
      end else if (acc < MIX_MIN) begin
        sum_nxt = MIX_MIN[SAMPLE_W-1:0];
      end else begin
        sum_nxt = acc[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      sum_r  <= '0;
    end else begin
      ctl2_r <= ctl_in;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      sum_r  <= clear ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gain2_r <= gain_in;
    mag3_r  <= mag_full;
    neg3_r  <= sample[SAMPLE_W-1];
    mag4_r  <= mag3_r;
    neg4_r  <= neg3_r;
    prod4_r <= mag3_r * GAIN_RECIP;
    q5_r    <= q;
    neg5_r  <= neg4_r;
  end

  assign res.done = ctl5_r.vld && ctl5_r.last;
  assign res.sum  = sum_nxt;

endmodule

// ===== hw/rtl/sample_voice_mixer.sv =====
// Multi-voice PCM sample player mixing all voices into one stereo frame per tick.
// Load and start words produce no result.
// A tick walks the voices one a cycle, once the result slot is free, through a 6-stage
// read/scale/accumulate pipeline; its frame is registered at the output (after any
// wait for an unread earlier frame), and no new word is taken until that frame is out.
// Reset clears control and marks every voice inactive; the memories are not cleared.
module sample_voice_mixer
  import smv_pkg::*;
#(
  parameter int VOICE_COUNT  = VOICE_COUNT_DEF,
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  smv_in_if.sink    in_if,
  smv_out_if.source out_if
);

  localparam int VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CW  = $clog2(VOICE_COUNT + 1);
  localparam int AW  = $clog2(SAMPLE_WORDS);
  localparam int AXW = (AW > 18) ? AW : 18;

  logic                       busy_r;
  logic [CW-1:0]              iss_cnt_r;
  logic                       s1_vld_r, s1_last_r;
  logic [VW-1:0]              s1_voice_r;
  logic [VOICE_COUNT-1:0]     active_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  logic          in_acc, do_load, do_start, do_tick, start_ok;
  logic [6:0]    voice_x;
  logic [VW-1:0] start_idx;
  logic          issue;
  voice_t        vt_rd, vt_wr;
  logic          vt_wr_en;
  logic [VW-1:0] vt_wr_addr;
  logic          s1_act, s1_hit;
  logic [AXW-1:0] rd_sum, ld_wide;
  mix_ctl_t      ctl1;
  mix_res_t      res;
  logic signed [SAMPLE_W-1:0] smp_rd;

  assign in_if.ready = !busy_r;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    do_load  = 1'b0;
    do_start = 1'b0;
    do_tick  = 1'b0;
    unique case (in_if.func)
      FUNC_LOAD:  do_load  = in_acc;
      FUNC_START: do_start = in_acc;
      FUNC_TICK:  do_tick  = in_acc;
      default: ;
    endcase
  end

  assign voice_x   = {3'b0, in_if.voice};
  assign start_ok  = do_start && (voice_x < 7'(VOICE_COUNT));
  assign start_idx = voice_x[VW-1:0];

  // walk the voices once the result slot is free
  assign issue = busy_r && !out_valid_r && (iss_cnt_r < CW'(VOICE_COUNT));

  assign s1_act = s1_vld_r && active_r[s1_voice_r];
  assign s1_hit = s1_act && (vt_rd.position < vt_rd.length);

  always_comb begin
    vt_wr_en   = 1'b0;
    vt_wr_addr = s1_voice_r;
    vt_wr      = vt_rd;
    if (start_ok) begin
      vt_wr_en       = 1'b1;
      vt_wr_addr     = start_idx;
      vt_wr.start    = in_if.address;
      vt_wr.length   = in_if.sample_length;
      vt_wr.position = '0;
      vt_wr.gain     = in_if.velocity;
    end else if (s1_hit) begin
      vt_wr_en       = 1'b1;
      vt_wr.position = vt_rd.position + 17'd1;
    end
  end

  assign rd_sum  = AXW'({1'b0, vt_rd.start} + {1'b0, vt_rd.position});
  assign ld_wide = AXW'(in_if.address);

  assign ctl1.vld  = s1_vld_r;
  assign ctl1.hit  = s1_hit;
  assign ctl1.last = s1_last_r;

  smv_voice_table #(.VOICE_COUNT(VOICE_COUNT)) u_voices (
    .clk     (clk),
    .wr_en   (vt_wr_en),
    .wr_addr (vt_wr_addr),
    .wr_data (vt_wr),
    .rd_en   (issue),
    .rd_addr (iss_cnt_r[VW-1:0]),
    .rd_data (vt_rd)
  );

  smv_sample_mem #(.SAMPLE_WORDS(SAMPLE_WORDS)) u_samples (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (ld_wide[AW-1:0]),
    .wr_data (in_if.sample_word),
    .rd_en   (s1_hit),
    .rd_addr (rd_sum[AW-1:0]),
    .rd_data (smp_rd)
  );

  smv_gain_acc u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (do_tick),
    .ctl_in  (ctl1),
    .gain_in (vt_rd.gain),
    .sample  (smp_rd),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      iss_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      s1_last_r   <= 1'b0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r  <= issue;
      s1_last_r <= issue && (iss_cnt_r == CW'(VOICE_COUNT - 1));
      if (do_tick) begin
        busy_r    <= 1'b1;
        iss_cnt_r <= '0;
      end else if (issue) begin
        iss_cnt_r <= iss_cnt_r + CW'(1);
      end
      if (start_ok) begin
        active_r[start_idx] <= 1'b1;
      end else if (s1_act && !s1_hit) begin
        // drop a voice that has played its length
        active_r[s1_voice_r] <= 1'b0;
      end
      if (res.done) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_voice_r <= iss_cnt_r[VW-1:0];
    if (res.done) begin
      out_data_r <= res.sum;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.left_sample  = out_data_r;
  assign out_if.right_sample = out_data_r;

endmodule

// ===== hw/rtl/smv_checker.sv =====
// Port-level checks of the sample voice mixer, bound to its top level.
module smv_checker
  import smv_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [FUNC_W-1:0]          in_func,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_left,
  input logic signed [SAMPLE_W-1:0] out_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left == out_right)
    else $error("left and right channels differ");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_TICK |=> !in_ready && !$rose(out_valid))
    else $error("tick did not hold off input for its mixing pass");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind sample_voice_mixer smv_checker u_smv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_func   (in_if.func),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_left  (out_if.left_sample),
  .out_right (out_if.right_sample)
);
